// File: rtl/core/irc_line_parser_defines.svh
// ----------------------------------------------------------------------------
// irc line parser assertion macros
// Concurrent checks on clk, disabled while arst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef IRC_LINE_PARSER_DEFINES_SVH
`define IRC_LINE_PARSER_DEFINES_SVH

`ifndef SYNTH

// ante holds in a cycle, cons holds in the same cycle
`define ILP_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("irc line parser check failed");

// ante holds in a cycle, cons holds in the next cycle
`define ILP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("irc line parser check failed");

`else

`define ILP_ASSERT_IMPLY(label, ante, cons)
`define ILP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/core/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg
// Types and constants shared by the irc line parser modules.
// ----------------------------------------------------------------------------
package ilp_pkg;

	localparam logic [7:0] ESC_BYTE   = 8'h10;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOWER_N = 8'h6E;
	localparam logic [7:0] CH_LOWER_R = 8'h72;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	localparam logic [7:0] PARAM_COUNT_MAX = 8'd255;
	localparam logic [7:0] CMD_LEN_MAX     = 8'd255;

	// command names, first character in the top byte
	localparam int NAME_MAX = 7;
	localparam logic [8*NAME_MAX-1:0] NAME_PRIVMSG = "PRIVMSG";
	localparam logic [8*NAME_MAX-1:0] NAME_NOTICE  = {"NOTICE", 8'h00};
	localparam logic [8*NAME_MAX-1:0] NAME_PING    = {"PING", 24'h0};
	localparam logic [8*NAME_MAX-1:0] NAME_NICK    = {"NICK", 24'h0};
	localparam logic [8*NAME_MAX-1:0] NAME_JOIN    = {"JOIN", 24'h0};
	localparam logic [8*NAME_MAX-1:0] NAME_PART    = {"PART", 24'h0};
	localparam logic [8*NAME_MAX-1:0] NAME_KICK    = {"KICK", 24'h0};
	localparam logic [8*NAME_MAX-1:0] NAME_QUIT    = {"QUIT", 24'h0};
	localparam logic [8*NAME_MAX-1:0] NAME_MODE    = {"MODE", 24'h0};
	localparam logic [8*NAME_MAX-1:0] NAME_TOPIC   = {"TOPIC", 16'h0};

	localparam int MAX_RESULTS = 3;
	localparam int FIFO_DEPTH  = 4;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_START,
		PH_PREFIX,
		PH_CMD,
		PH_PSTART,
		PH_MIDDLE,
		PH_TSTART,
		PH_TRAIL
	} phase_t;

	typedef enum logic [1:0] {
		ROLE_PREFIX,
		ROLE_COMMAND,
		ROLE_MIDDLE,
		ROLE_TRAILING
	} role_t;

	typedef enum logic [3:0] {
		MT_PRIVMSG,
		MT_NUMERIC,
		MT_NOTICE,
		MT_PING,
		MT_NICK,
		MT_JOIN,
		MT_PART,
		MT_KICK,
		MT_QUIT,
		MT_CHANMODE,
		MT_NICKMODE,
		MT_TOPIC,
		MT_UNKNOWN
	} msg_type_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		role_t      role;
		logic [7:0] param_index;
		msg_type_t  msg_type;
		logic       last;
	} result_t;

	// results caused by one input transaction, packed from slot 0
	typedef struct packed {
		logic [1:0]                     count;
		result_t [MAX_RESULTS-1:0]      slot;
	} burst_t;

endpackage

// File: rtl/core/ilp_line_if.sv
// ----------------------------------------------------------------------------
// ilp_line_if
// Raw line byte channel: valid/ready with byte and end-of-line mark.
// ----------------------------------------------------------------------------
interface ilp_line_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       line_end;

	modport source (output valid, line_byte, line_end, input ready);
	modport sink (input valid, line_byte, line_end, output ready);
endinterface

// File: rtl/core/ilp_token_if.sv
// ----------------------------------------------------------------------------
// ilp_token_if
// Parsed token channel: valid/ready with tagged content byte or token end.
// ----------------------------------------------------------------------------
interface ilp_token_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic [1:0] token_role;
	logic [7:0] param_index;
	logic [3:0] message_type;
	logic       last;

	modport source (output valid, kind, data_byte, token_role, param_index,
		message_type, last, input ready);
	modport sink (input valid, kind, data_byte, token_role, param_index,
		message_type, last, output ready);
endinterface

// File: rtl/core/ilp_parse.sv
// ----------------------------------------------------------------------------
// ilp_parse
// Holdback, unquoting and token split for one byte; parser state update.
// ----------------------------------------------------------------------------
module ilp_parse #(
	parameter int COMMAND_KEEP = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      line_byte,
	input  logic            line_end,
	output ilp_pkg::burst_t burst
);
	import ilp_pkg::*;

	localparam int IDX_W = $clog2(COMMAND_KEEP);

	typedef struct packed {
		phase_t                         phase;
		logic [7:0]                     cmd_len;
		logic [7:0]                     params;
		logic                           chan;
		logic [COMMAND_KEEP-1:0][7:0]   cmd;
	} pstate_t;

	typedef struct packed {
		pstate_t st;
		logic    v;
		result_t r;
	} pout_t;

	function automatic result_t mk(logic kind, logic [7:0] d, role_t role,
		logic [7:0] idx);
		result_t r;
		r.kind        = kind;
		r.data_byte   = d;
		r.role        = role;
		r.param_index = idx;
		r.msg_type    = MT_UNKNOWN;
		r.last        = 1'b0;
		return r;
	endfunction

	function automatic logic [7:0] bump(logic [7:0] p);
		return (p < PARAM_COUNT_MAX) ? p + 8'd1 : p;
	endfunction

	function automatic logic is_chan(logic [7:0] c);
		return (c == CH_HASH) || (c == CH_AMP);
	endfunction

	function automatic logic [7:0] upper(logic [7:0] c);
		return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_DELTA : c;
	endfunction

	function automatic pstate_t idle_state();
		pstate_t s;
		s       = '0;
		s.phase = PH_START;
		return s;
	endfunction

	function automatic pout_t parse_byte(pstate_t s, logic [7:0] c);
		pout_t  o;
		phase_t ph;
		o.st = s;
		o.v  = 1'b0;
		o.r  = mk(1'b0, CH_NUL, ROLE_PREFIX, 8'd0);
		ph   = s.phase;
		if (ph == PH_START) begin
			ph         = (c == CH_COLON) ? PH_START : PH_CMD;
			o.st.phase = (c == CH_COLON) ? PH_PREFIX : PH_CMD;
		end
		unique case (ph)
			PH_PREFIX: begin
				o.v = 1'b1;
				if (c == CH_SPACE) begin
					o.st.phase = PH_CMD;
					o.r        = mk(1'b1, CH_NUL, ROLE_PREFIX, 8'd0);
				end else begin
					o.r = mk(1'b0, c, ROLE_PREFIX, 8'd0);
				end
			end
			PH_CMD: begin
				o.v = 1'b1;
				if (c == CH_SPACE) begin
					o.st.phase = PH_PSTART;
					o.r        = mk(1'b1, CH_NUL, ROLE_COMMAND, 8'd0);
				end else begin
					if (s.cmd_len < 8'(COMMAND_KEEP))
						o.st.cmd[s.cmd_len[IDX_W-1:0]] = c;
					if (s.cmd_len != CMD_LEN_MAX)
						o.st.cmd_len = s.cmd_len + 8'd1;
					o.r = mk(1'b0, c, ROLE_COMMAND, 8'd0);
				end
			end
			PH_PSTART: begin
				if (c == CH_COLON) begin
					o.st.phase = PH_TSTART;
				end else if (c == CH_SPACE) begin
					o.v         = 1'b1;
					o.r         = mk(1'b1, CH_NUL, ROLE_MIDDLE, s.params);
					o.st.params = bump(s.params);
				end else begin
					if (s.params == 8'd0)
						o.st.chan = is_chan(c);
					o.st.phase = PH_MIDDLE;
					o.v        = 1'b1;
					o.r        = mk(1'b0, c, ROLE_MIDDLE, s.params);
				end
			end
			PH_MIDDLE: begin
				o.v = 1'b1;
				if (c == CH_SPACE) begin
					o.r         = mk(1'b1, CH_NUL, ROLE_MIDDLE, s.params);
					o.st.params = bump(s.params);
					o.st.phase  = PH_PSTART;
				end else begin
					o.r = mk(1'b0, c, ROLE_MIDDLE, s.params);
				end
			end
			PH_TSTART: begin
				if (s.params == 8'd0)
					o.st.chan = is_chan(c);
				o.st.phase = PH_TRAIL;
				o.v        = 1'b1;
				o.r        = mk(1'b0, c, ROLE_TRAILING, s.params);
			end
			PH_TRAIL: begin
				o.v = 1'b1;
				o.r = mk(1'b0, c, ROLE_TRAILING, s.params);
			end
			// line start with ':' lands here: prefix opens, nothing emitted
			default: begin
				if (ph != PH_START)
					o.st.phase = PH_START;
			end
		endcase
		return o;
	endfunction

	function automatic logic name_is(pstate_t s, logic [8*NAME_MAX-1:0] name,
		logic [2:0] nlen);
		logic ok;
		ok = (s.cmd_len == {5'd0, nlen});
		for (int i = 0; i < NAME_MAX; i++) begin
			if (i < int'(nlen) && upper(s.cmd[IDX_W'(i)]) != name[8*(NAME_MAX-1-i) +: 8])
				ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic msg_type_t msg_type(pstate_t s);
		msg_type_t t;
		logic      two, one;
		two = (s.params >= 8'd2);
		one = (s.params >= 8'd1);
		priority if (name_is(s, NAME_PRIVMSG, 3'd7) && two)
			t = MT_PRIVMSG;
		else if (s.cmd_len != 8'd0 && s.cmd[0] >= CH_ZERO && s.cmd[0] <= CH_NINE)
			t = MT_NUMERIC;
		else if (name_is(s, NAME_NOTICE, 3'd6) && two)
			t = MT_NOTICE;
		else if (name_is(s, NAME_PING, 3'd4) && one)
			t = MT_PING;
		else if (name_is(s, NAME_NICK, 3'd4) && one)
			t = MT_NICK;
		else if (name_is(s, NAME_JOIN, 3'd4) && one)
			t = MT_JOIN;
		else if (name_is(s, NAME_PART, 3'd4) && one)
			t = MT_PART;
		else if (name_is(s, NAME_KICK, 3'd4) && two)
			t = MT_KICK;
		else if (name_is(s, NAME_QUIT, 3'd4))
			t = MT_QUIT;
		else if (name_is(s, NAME_MODE, 3'd4) && one)
			t = s.chan ? MT_CHANMODE : MT_NICKMODE;
		else if (name_is(s, NAME_TOPIC, 3'd5) && two)
			t = MT_TOPIC;
		else
			t = MT_UNKNOWN;
		return t;
	endfunction

	pstate_t         st_q, st_d;
	logic            esc_q, esc_d;
	logic [1:0][7:0] hold_q, hold_d;
	logic [1:0]      hcnt_q, hcnt_d;

	logic       release_byte;
	logic [7:0] raw;
	logic       esc_after;
	logic       do1, do2;
	logic [7:0] c1, c2;
	pout_t      p1, p2;
	pstate_t    st1, st2, fin;
	result_t    rf;
	logic       v1, v2;

	// holdback: a byte is released only once two newer bytes are held
	always_comb begin
		release_byte = hcnt_q[1];
		raw          = hold_q[0];
		hold_d       = hold_q;
		hcnt_d       = hcnt_q;
		if (release_byte) begin
			hold_d[0] = hold_q[1];
			hold_d[1] = line_byte;
		end else begin
			hold_d[hcnt_q[0]] = line_byte;
			hcnt_d            = hcnt_q + 2'd1;
		end
		if (line_end)
			hcnt_d = 2'd0;
	end

	// unquoting: up to two parser calls, the second also serves a quote at line end
	always_comb begin
		do1       = 1'b0;
		do2       = 1'b0;
		c1        = raw;
		c2        = raw;
		esc_after = esc_q;
		if (release_byte) begin
			if (esc_q) begin
				esc_after = 1'b0;
				do1       = 1'b1;
				priority if (raw == ESC_BYTE)
					c1 = ESC_BYTE;
				else if (raw == CH_ZERO)
					c1 = CH_NUL;
				else if (raw == CH_LOWER_N)
					c1 = CH_LF;
				else if (raw == CH_LOWER_R)
					c1 = CH_CR;
				else begin
					c1  = ESC_BYTE;
					do2 = 1'b1;
				end
			end else if (raw == ESC_BYTE) begin
				esc_after = 1'b1;
			end else begin
				do1 = 1'b1;
			end
		end
		if (line_end && esc_after) begin
			do2       = 1'b1;
			c2        = ESC_BYTE;
			esc_after = 1'b0;
		end
	end

	always_comb begin
		p1  = parse_byte(st_q, c1);
		st1 = do1 ? p1.st : st_q;
		p2  = parse_byte(st1, c2);
		st2 = do2 ? p2.st : st1;
		v1  = do1 && p1.v;
		v2  = do2 && p2.v;
	end

	// final result closes the open token through the implied space
	always_comb begin
		fin = st2;
		rf  = mk(1'b1, CH_NUL, ROLE_COMMAND, 8'd0);
		unique case (st2.phase)
			PH_PREFIX: rf.role = ROLE_PREFIX;
			PH_PSTART, PH_MIDDLE: begin
				rf.role        = ROLE_MIDDLE;
				rf.param_index = st2.params;
				fin.params     = bump(st2.params);
			end
			PH_TSTART, PH_TRAIL: begin
				rf.role        = ROLE_TRAILING;
				rf.param_index = st2.params;
				fin.params     = bump(st2.params);
			end
			default: rf.role = ROLE_COMMAND;
		endcase
		rf.msg_type = msg_type(fin);
		rf.last     = 1'b1;
	end

	always_comb begin
		burst.count   = {1'b0, v1} + {1'b0, v2} + {1'b0, line_end};
		burst.slot[0] = v1 ? p1.r : (v2 ? p2.r : rf);
		burst.slot[1] = (v1 && v2) ? p2.r : rf;
		burst.slot[2] = rf;
		st_d          = line_end ? idle_state() : st2;
		esc_d         = esc_after;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= idle_state();
			esc_q  <= 1'b0;
			hold_q <= '0;
			hcnt_q <= 2'd0;
		end else if (fire) begin
			st_q   <= st_d;
			esc_q  <= esc_d;
			hold_q <= hold_d;
			hcnt_q <= hcnt_d;
		end
	end

endmodule

// File: rtl/core/irc_line_parser.sv
// ----------------------------------------------------------------------------
// irc_line_parser
// Streaming parser for received IRC lines.
// The line channel carries one raw byte per transaction, line_end set on the
// final byte; the last two bytes of every line are dropped as CR LF.
// The token channel gives content bytes tagged with role and parameter index
// and a token-end transaction per token; the final transaction of a line has
// last set and carries message_type.
// A byte is registered on acceptance and parsed once the queue has room, its
// results entering a four-entry output queue; a result is visible in the cycle
// after the parse. A byte's content appears once two later bytes have come.
// Throughput is one byte per cycle while each byte gives at most one result
// and the receiver keeps taking results; a byte is parsed only while the queue
// holds at most one entry, so after a byte giving two or three results (escape
// pass-through, line end) the next byte waits while the queue drains.
// When the receiver stalls the queue fills and the line channel drops ready
// one byte later; nothing is lost. Reset empties the queue and the input
// register and returns the parser to line start.
// ----------------------------------------------------------------------------
`include "irc_line_parser_defines.svh"

module irc_line_parser #(
	parameter int COMMAND_KEEP = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	ilp_line_if.sink    line,
	ilp_token_if.source tokens
);
	import ilp_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             end_s1;
	logic             fire;
	logic             pop;
	burst_t           burst;
	result_t          fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	result_t          head;

	assign fire       = valid_s1 && (count_q <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));
	assign line.ready = !valid_s1 || fire;
	assign pop        = tokens.valid && tokens.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line.ready) begin
			valid_s1 <= line.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line.ready && line.valid) begin
			byte_s1 <= line.line_byte;
			end_s1  <= line.line_end;
		end
	end

	ilp_parse #(
		.COMMAND_KEEP(COMMAND_KEEP)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.line_byte (byte_s1),
		.line_end  (end_s1),
		.burst     (burst)
	);

	// burst lands in consecutive queue slots from the write pointer
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (fire && k < int'(burst.count))
				fifo_q[PTR_W'(wr_ptr_q + PTR_W'(k))] <= burst.slot[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (fire)
				wr_ptr_q <= PTR_W'(wr_ptr_q + PTR_W'(burst.count));
			if (pop)
				rd_ptr_q <= PTR_W'(rd_ptr_q + PTR_W'(1));
			count_q <= count_q + (fire ? CNT_W'(burst.count) : CNT_W'(0))
				- CNT_W'(pop);
		end
	end

	assign head                = fifo_q[rd_ptr_q];
	assign tokens.valid        = (count_q != '0);
	assign tokens.kind         = head.kind;
	assign tokens.data_byte    = head.data_byte;
	assign tokens.token_role   = head.role;
	assign tokens.param_index  = head.param_index;
	assign tokens.message_type = head.msg_type;
	assign tokens.last         = head.last;

	// a line end always closes its burst with the last-marked result
	`ILP_ASSERT_IMPLY(a_end_gives_last, fire && end_s1, burst.count != 2'd0 && burst.slot[burst.count - 2'd1].last)
	// a byte within the line never produces a last-marked result
	`ILP_ASSERT_IMPLY(a_no_early_last, fire && !end_s1, burst.count != 2'd3 && !(burst.count != 2'd0 && burst.slot[0].last) && !(burst.count == 2'd2 && burst.slot[1].last))
	// queue occupancy stays within its depth
	`ILP_ASSERT_IMPLY(a_queue_bound, tokens.valid, count_q <= CNT_W'(FIFO_DEPTH))
	// taking the only queued result with no new burst empties the queue
	`ILP_ASSERT_NEXT(a_queue_drains, pop && count_q == CNT_W'(1) && !fire, !tokens.valid)

endmodule

// File: dv/tb_irc_line_parser.sv
// ----------------------------------------------------------------------------
// tb_irc_line_parser
// Drives raw IRC lines into the parser and checks every token transaction
// against a local line predictor: a short directed table (short lines, prefix
// only, quoting, trailing space), then random messages mixed with noise.
// Both channels stall at random, and the token side holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_irc_line_parser;
	import ilp_pkg::*;

	localparam int CMD_KEEP     = 7;
	localparam int RAND_ITEMS   = 80;
	localparam int LONG_HOLD    = 90;
	localparam int DRAIN_CYCLES = 16;
	localparam int STALL_LIMIT  = 2000;
	localparam int N_DIR        = 23;

	typedef struct packed {
		logic [7:0] b;
		logic       e;
		logic       typed;
		logic [1:0] n_typed;
		result_t    tok;
	} stim_row_t;

	localparam result_t NO_TOKEN = '0;
	localparam result_t LINE_END_EMPTY = '{kind: 1'b1, data_byte: 8'h00, role: ROLE_COMMAND,
		param_index: 8'h00, msg_type: MT_UNKNOWN, last: 1'b1};

	localparam stim_row_t DIR_ROWS [N_DIR] = '{
		// two-byte line, then a one-byte line: only the final token end each
		'{8'h0D, 1'b0, 1'b1, 2'd0, NO_TOKEN},
		'{8'h0A, 1'b1, 1'b1, 2'd1, LINE_END_EMPTY},
		'{8'hFF, 1'b1, 1'b1, 2'd1, LINE_END_EMPTY},
		// line ends inside the prefix, last content byte a lone quote char
		'{CH_COLON, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{8'h00, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{ESC_BYTE, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{CH_CR, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{CH_LF, 1'b1, 1'b0, 2'd0, NO_TOKEN},
		// every unquote pair, a pass-through quote, then a trailing space
		'{8'h6D, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{ESC_BYTE, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{ESC_BYTE, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{CH_SPACE, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{ESC_BYTE, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{CH_ZERO, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{ESC_BYTE, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{CH_LOWER_N, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{ESC_BYTE, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{CH_LOWER_R, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{ESC_BYTE, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{8'h7A, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{CH_SPACE, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{CH_CR, 1'b0, 1'b0, 2'd0, NO_TOKEN},
		'{CH_LF, 1'b1, 1'b0, 2'd0, NO_TOKEN}
	};

	localparam logic [8*NAME_MAX-1:0] CMD_NAMES [10] = '{NAME_PRIVMSG, NAME_NOTICE,
		NAME_PING, NAME_NICK, NAME_JOIN, NAME_PART, NAME_KICK, NAME_QUIT, NAME_MODE,
		NAME_TOPIC};

	logic clk;
	logic arst_n;

	ilp_line_if  line_ch ();
	ilp_token_if tok_ch ();

	irc_line_parser #(.COMMAND_KEEP(CMD_KEEP)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.line   (line_ch),
		.tokens (tok_ch)
	);

	// line predictor state
	logic [7:0] held [2];
	int         held_n;
	bit         esc_wait;
	phase_t     ph;
	logic [7:0] cmd_buf [CMD_KEEP];
	logic [7:0] cmd_len;
	logic [7:0] par_cnt;
	bit         chan_first;

	result_t    step_tokens[$];
	result_t    pending_tokens[$];
	result_t    tok_want;
	logic [7:0] txt[$];

	bit         steady_in;
	bit         held_off;
	int         errors;
	int         checked;
	int         bytes_in;
	int         lines_sent;
	int         quiet;
	bit [15:0]  seen_types;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void add_token(input logic k, input logic [7:0] d, input role_t ro,
		input logic [7:0] idx, input msg_type_t mt, input logic lst);
		result_t r;
		r.kind        = k;
		r.data_byte   = d;
		r.role        = ro;
		r.param_index = idx;
		r.msg_type    = mt;
		r.last        = lst;
		step_tokens.insert(step_tokens.size(), r);
	endfunction

	function automatic void bump_param_count();
		if (par_cnt < PARAM_COUNT_MAX)
			par_cnt++;
	endfunction

	function automatic void clear_line_state();
		int i;
		held_n     = 0;
		esc_wait   = 1'b0;
		ph         = PH_START;
		for (i = 0; i < CMD_KEEP; i++)
			cmd_buf[i] = 8'h00;
		cmd_len    = 8'h00;
		par_cnt    = 8'h00;
		chan_first = 1'b0;
	endfunction

	function automatic void scan_char(input logic [7:0] c);
		if (ph == PH_START) begin
			if (c == CH_COLON) begin
				ph = PH_PREFIX;
				return;
			end
			ph = PH_CMD;
		end
		case (ph)
			PH_PREFIX: begin
				if (c == CH_SPACE) begin
					ph = PH_CMD;
					add_token(1'b1, 8'h00, ROLE_PREFIX, 8'h00, MT_UNKNOWN, 1'b0);
				end else
					add_token(1'b0, c, ROLE_PREFIX, 8'h00, MT_UNKNOWN, 1'b0);
			end
			PH_CMD: begin
				if (c == CH_SPACE) begin
					ph = PH_PSTART;
					add_token(1'b1, 8'h00, ROLE_COMMAND, 8'h00, MT_UNKNOWN, 1'b0);
				end else begin
					if (cmd_len < CMD_KEEP)
						cmd_buf[cmd_len[2:0]] = c;
					if (cmd_len < CMD_LEN_MAX)
						cmd_len++;
					add_token(1'b0, c, ROLE_COMMAND, 8'h00, MT_UNKNOWN, 1'b0);
				end
			end
			PH_PSTART: begin
				if (c == CH_COLON)
					ph = PH_TSTART;
				else if (c == CH_SPACE) begin
					add_token(1'b1, 8'h00, ROLE_MIDDLE, par_cnt, MT_UNKNOWN, 1'b0);
					bump_param_count();
				end else begin
					if (par_cnt == 8'h00)
						chan_first = (c == CH_HASH || c == CH_AMP);
					ph = PH_MIDDLE;
					add_token(1'b0, c, ROLE_MIDDLE, par_cnt, MT_UNKNOWN, 1'b0);
				end
			end
			PH_MIDDLE: begin
				if (c == CH_SPACE) begin
					add_token(1'b1, 8'h00, ROLE_MIDDLE, par_cnt, MT_UNKNOWN, 1'b0);
					bump_param_count();
					ph = PH_PSTART;
				end else
					add_token(1'b0, c, ROLE_MIDDLE, par_cnt, MT_UNKNOWN, 1'b0);
			end
			PH_TSTART: begin
				if (par_cnt == 8'h00)
					chan_first = (c == CH_HASH || c == CH_AMP);
				ph = PH_TRAIL;
				add_token(1'b0, c, ROLE_TRAILING, par_cnt, MT_UNKNOWN, 1'b0);
			end
			PH_TRAIL: add_token(1'b0, c, ROLE_TRAILING, par_cnt, MT_UNKNOWN, 1'b0);
			default: ph = PH_START;
		endcase
	endfunction

	function automatic void unquote_byte(input logic [7:0] r);
		if (esc_wait) begin
			esc_wait = 1'b0;
			case (r)
				ESC_BYTE:   scan_char(ESC_BYTE);
				CH_ZERO:    scan_char(CH_NUL);
				CH_LOWER_N: scan_char(CH_LF);
				CH_LOWER_R: scan_char(CH_CR);
				default: begin
					scan_char(ESC_BYTE);
					scan_char(r);
				end
			endcase
		end else if (r == ESC_BYTE)
			esc_wait = 1'b1;
		else
			scan_char(r);
	endfunction

	// whole-command match, case-insensitive; a longer command never matches
	function automatic bit cmd_is(input logic [8*NAME_MAX-1:0] nm);
		int n;
		int i;
		logic [7:0] c;
		n = 0;
		for (i = 0; i < NAME_MAX; i++)
			if (n == i && nm[8*(NAME_MAX-1-i) +: 8] != 8'h00)
				n = i + 1;
		if (int'(cmd_len) != n || n > CMD_KEEP)
			return 1'b0;
		for (i = 0; i < n; i++) begin
			c = cmd_buf[i];
			if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
				c = c - CASE_DELTA;
			if (c != nm[8*(NAME_MAX-1-i) +: 8])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic msg_type_t line_type();
		if (cmd_is(NAME_PRIVMSG) && par_cnt >= 2) return MT_PRIVMSG;
		if (cmd_len > 0 && cmd_buf[0] >= CH_ZERO && cmd_buf[0] <= CH_NINE) return MT_NUMERIC;
		if (cmd_is(NAME_NOTICE) && par_cnt >= 2) return MT_NOTICE;
		if (cmd_is(NAME_PING) && par_cnt >= 1) return MT_PING;
		if (cmd_is(NAME_NICK) && par_cnt >= 1) return MT_NICK;
		if (cmd_is(NAME_JOIN) && par_cnt >= 1) return MT_JOIN;
		if (cmd_is(NAME_PART) && par_cnt >= 1) return MT_PART;
		if (cmd_is(NAME_KICK) && par_cnt >= 2) return MT_KICK;
		if (cmd_is(NAME_QUIT)) return MT_QUIT;
		if (cmd_is(NAME_MODE) && par_cnt >= 1) return chan_first ? MT_CHANMODE : MT_NICKMODE;
		if (cmd_is(NAME_TOPIC) && par_cnt >= 2) return MT_TOPIC;
		return MT_UNKNOWN;
	endfunction

	// the implied space that closes the line
	function automatic void end_line();
		role_t ro;
		logic [7:0] idx;
		ro  = ROLE_COMMAND;
		idx = 8'h00;
		case (ph)
			PH_PREFIX: ro = ROLE_PREFIX;
			PH_PSTART, PH_MIDDLE: begin
				ro  = ROLE_MIDDLE;
				idx = par_cnt;
				bump_param_count();
			end
			PH_TSTART, PH_TRAIL: begin
				ro  = ROLE_TRAILING;
				idx = par_cnt;
				bump_param_count();
			end
			default: ;
		endcase
		add_token(1'b1, 8'h00, ro, idx, line_type(), 1'b1);
		clear_line_state();
	endfunction

	function automatic void predict_tokens(input logic [7:0] b, input logic e);
		logic [7:0] r;
		step_tokens.delete();
		if (held_n >= 2) begin
			r       = held[0];
			held[0] = held[1];
			held[1] = b;
			unquote_byte(r);
		end else begin
			held[held_n[0]] = b;
			held_n++;
		end
		if (e) begin
			if (esc_wait) begin
				esc_wait = 1'b0;
				scan_char(ESC_BYTE);
			end
			end_line();
		end
	endfunction

	// mostly no gap, sometimes a short one, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic void put_txt(input logic [7:0] b);
		txt.insert(txt.size(), b);
	endfunction

	function automatic void put_word(input int len, input bit with_space);
		int k;
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 11) == 0) begin
				put_txt(ESC_BYTE);
				case ($urandom_range(0, 4))
					0: put_txt(ESC_BYTE);
					1: put_txt(CH_ZERO);
					2: put_txt(CH_LOWER_N);
					3: put_txt(CH_LOWER_R);
					default: put_txt(8'($urandom_range(8'h21, 8'h7E)));
				endcase
			end else if (with_space && $urandom_range(0, 5) == 0)
				put_txt(CH_SPACE);
			else
				put_txt(8'($urandom_range(8'h21, 8'h7E)));
		end
	endfunction

	task automatic drive_byte(input logic [7:0] b, input logic e, input logic typed,
		input logic [1:0] n_typed, input result_t typed_tok);
		int gap;
		gap = steady_in ? 0 : pick_gap();
		if (gap > 0) begin
			line_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		line_ch.valid     <= 1'b1;
		line_ch.line_byte <= b;
		line_ch.line_end  <= e;
		@(posedge clk);
		while (!line_ch.ready) @(posedge clk);
		bytes_in++;
		if (e)
			lines_sent++;
		predict_tokens(b, e);
		if (typed) begin
			if (n_typed != 2'd0)
				pending_tokens.insert(pending_tokens.size(), typed_tok);
		end else
			foreach (step_tokens[k])
				pending_tokens.insert(pending_tokens.size(), step_tokens[k]);
	endtask

	task automatic send_text();
		int i;
		for (i = 0; i < txt.size(); i++)
			drive_byte(txt[i], i == txt.size() - 1, 1'b0, 2'd0, NO_TOKEN);
	endtask

	function automatic void check_field(input string fname, input logic [7:0] exp_v,
		input logic [7:0] got_v);
		if (exp_v !== got_v) begin
			errors++;
			$display("%0t: token transaction %0d, %s expected %0h got %0h",
				$time, checked, fname, exp_v, got_v);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && tok_ch.valid && tok_ch.ready) begin
			checked++;
			if (pending_tokens.size() == 0) begin
				errors++;
				$display("%0t: token transaction with nothing expected, kind %0h data %02h last %0h",
					$time, tok_ch.kind, tok_ch.data_byte, tok_ch.last);
			end else begin
				tok_want = pending_tokens.pop_front();
				check_field("kind", 8'(tok_want.kind), 8'(tok_ch.kind));
				check_field("data_byte", tok_want.data_byte, tok_ch.data_byte);
				check_field("token_role", 8'(tok_want.role), 8'(tok_ch.token_role));
				check_field("param_index", tok_want.param_index, tok_ch.param_index);
				check_field("message_type", 8'(tok_want.msg_type), 8'(tok_ch.message_type));
				check_field("last", 8'(tok_want.last), 8'(tok_ch.last));
				if (tok_ch.last === 1'b1 && !$isunknown(tok_ch.message_type))
					seen_types[tok_ch.message_type] = 1'b1;
			end
		end
	end

	// watchdog: cycles in which neither channel moves a transaction
	always @(posedge clk) begin
		if (!arst_n || (line_ch.valid && line_ch.ready) || (tok_ch.valid && tok_ch.ready))
			quiet = 0;
		else begin
			quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// token receiver
	initial begin
		int gap;
		tok_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && bytes_in >= 50) begin
				// long hold-off so the output queue fills and the line side stalls
				held_off = 1'b1;
				tok_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if ($urandom_range(0, 4) == 0) begin
				tok_ch.ready <= 1'b1;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else begin
				tok_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					tok_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int i;
		int pick;
		int np;
		int p;
		int rnd_bytes;
		logic [7:0] c;
		logic [8*NAME_MAX-1:0] nm;

		arst_n            = 1'b0;
		line_ch.valid     = 1'b0;
		line_ch.line_byte = 8'h00;
		line_ch.line_end  = 1'b0;
		held[0]           = 8'h00;
		held[1]           = 8'h00;
		clear_line_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIR; i++) begin
			steady_in = ($urandom_range(0, 1) == 0);
			drive_byte(DIR_ROWS[i].b, DIR_ROWS[i].e, DIR_ROWS[i].typed,
				DIR_ROWS[i].n_typed, DIR_ROWS[i].tok);
		end

		rnd_bytes = 0;
		while (rnd_bytes < RAND_ITEMS) begin
			txt.delete();
			steady_in = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 1)) begin
					put_txt(CH_COLON);
					put_word($urandom_range(1, 5), 1'b0);
					put_txt(CH_SPACE);
				end
				pick = $urandom_range(0, 12);
				if (pick < 11) begin
					nm = CMD_NAMES[pick % 10];
					for (i = 0; i < NAME_MAX; i++) begin
						c = nm[8*(NAME_MAX-1-i) +: 8];
						if (c != 8'h00)
							put_txt(($urandom_range(0, 3) == 0) ? c + CASE_DELTA : c);
					end
					// one character too many, must not match
					if (pick == 10)
						put_txt(CH_LOWER_A);
				end else if (pick == 11) begin
					for (i = 0; i < 3; i++)
						put_txt(8'($urandom_range(CH_ZERO, CH_NINE)));
				end else begin
					np = $urandom_range(1, 9);
					for (i = 0; i < np; i++)
						put_txt(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)) -
							($urandom_range(0, 1) ? CASE_DELTA : 8'h00));
				end
				np = $urandom_range(0, 4);
				for (p = 0; p < np; p++) begin
					put_txt(CH_SPACE);
					if (p == 0 && $urandom_range(0, 1))
						put_txt($urandom_range(0, 1) ? CH_HASH : CH_AMP);
					put_word($urandom_range(0, 4), 1'b0);
				end
				if ($urandom_range(0, 1)) begin
					put_txt(CH_SPACE);
					put_txt(CH_COLON);
					put_word($urandom_range(0, 8), 1'b1);
				end else if ($urandom_range(0, 7) == 0)
					put_txt(CH_SPACE);
				if ($urandom_range(0, 7) == 0) begin
					put_txt(8'($urandom_range(0, 255)));
					put_txt(8'($urandom_range(0, 255)));
				end else begin
					put_txt(CH_CR);
					put_txt(CH_LF);
				end
			end else begin
				// noise, biased toward the bytes the parser reacts to
				np = $urandom_range(1, 14);
				for (i = 0; i < np; i++) begin
					if ($urandom_range(0, 2) == 0)
						case ($urandom_range(0, 3))
							0: put_txt(CH_SPACE);
							1: put_txt(CH_COLON);
							2: put_txt(ESC_BYTE);
							default: put_txt(CH_HASH);
						endcase
					else
						put_txt(8'($urandom_range(0, 255)));
				end
			end
			rnd_bytes += txt.size();
			send_text();
		end
		line_ch.valid <= 1'b0;

		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d lines in %0d bytes, checked %0d token transactions",
			lines_sent, bytes_in, checked);
		$display("line ends covered %0d of 13 message types, output hold-off %0s",
			$countones(seen_types), held_off ? "done" : "not reached");
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
